[hdl/wcdma_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Walsh CDMA package
// Shared types, codes and default sizes for the Walsh-Hadamard spreader and
// despreader over one shared chip store.
// ----------------------------------------------------------------------------
package wcdma_pkg;

  // Default store geometry.
  localparam int MAX_BITS_DEF     = 64;
  localparam int MAX_CODE_LEN_DEF = 64;

  // Field widths.
  localparam int KIND_W   = 2;
  localparam int USER_W   = 6;
  localparam int POS_W    = 6;
  localparam int CHIP_W   = 8;
  localparam int LEVEL_W  = 8;
  localparam int CLOG_W   = 3;
  localparam int USERS_W  = 6;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SPREAD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DESPREAD = 2'd2;

  // Register indexes (bit 2 of the byte address).
  localparam logic REG_CODE_LOG2    = 1'b0;
  localparam logic REG_ACTIVE_USERS = 1'b1;

  // Register reset values.
  localparam logic [CLOG_W-1:0]  CODE_LOG2_RST    = 3'd1;
  localparam logic [USERS_W-1:0] ACTIVE_USERS_RST = 6'd1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Control of the shared add unit.
  typedef struct packed {
    logic spread;
    logic negate;
  } mac_ctrl_t;

endpackage : wcdma_pkg
`default_nettype wire

[hdl/wcdma_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wcdma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule : wcdma_ram
`default_nettype wire

[hdl/wcdma_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Walsh CDMA shared add unit
// One adder used for both jobs: a chip plus or minus one with 8-bit
// saturation when spreading, and a correlation accumulate when despreading.
// ----------------------------------------------------------------------------
module wcdma_mac #(
  parameter int ACC_W = 15
) (
  input  wire wcdma_pkg::mac_ctrl_t                   ctrl,
  input  wire logic signed [ACC_W-1:0]                acc,
  input  wire logic signed [wcdma_pkg::CHIP_W-1:0]    chip,
  output logic signed      [ACC_W-1:0]                sum,
  output logic signed      [wcdma_pkg::CHIP_W-1:0]    chip_sat
);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(127);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(128);
  localparam logic signed [ACC_W-1:0] ONE    = ACC_W'(1);

  logic signed [ACC_W-1:0] chip_ext;
  logic signed [ACC_W-1:0] op_a;
  logic signed [ACC_W-1:0] op_b;

  always_comb begin
    chip_ext = ACC_W'(chip);
    if (ctrl.spread) begin
      op_a = chip_ext;
      op_b = ctrl.negate ? -ONE : ONE;
    end else begin
      op_a = acc;
      op_b = ctrl.negate ? -chip_ext : chip_ext;
    end
    sum = op_a + op_b;
    if (sum > SAT_HI) begin
      chip_sat = 8'sd127;
    end else if (sum < SAT_LO) begin
      chip_sat = -8'sd128;
    end else begin
      chip_sat = sum[wcdma_pkg::CHIP_W-1:0];
    end
  end

endmodule : wcdma_mac
`default_nettype wire

[hdl/walsh_cdma_spread_despread_top.sv]
`default_nettype none
// Spread and despread items run over L = 2^code_log2 chips (a log2 of zero
// counts as one, L capped by MAX_CODE_LEN), one chip per cycle through the RAM and the
// shared adder. No new item is accepted until the current one is through, and a despread
// level waits to enter the result register while a held level still fills it. A clear
// item sweeps all MAX_BITS*MAX_CODE_LEN store words; ignored items leave the sequencer idle.
// After reset the store is swept with in_ready low.
// ----------------------------------------------------------------------------
// Walsh CDMA spreader and despreader
// Spreads data bits with Walsh-Hadamard codes into a shared saturating chip
// store and correlates them back out per user.
// ----------------------------------------------------------------------------
module walsh_cdma_spread_despread_top #(
  parameter int MAX_BITS     = wcdma_pkg::MAX_BITS_DEF,
  parameter int MAX_CODE_LEN = wcdma_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [wcdma_pkg::CFG_AW-1:0]        cfg_paddr,
  input  wire logic [wcdma_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic      [wcdma_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                                     cfg_pready,
  // Input items
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [wcdma_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [wcdma_pkg::USER_W-1:0]        in_user,
  input  wire logic [wcdma_pkg::POS_W-1:0]         in_bit_position,
  input  wire logic                                in_data_bit,
  // Result items
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [wcdma_pkg::LEVEL_W-1:0]     out_level
);

  localparam int STORE_DEPTH = MAX_BITS * MAX_CODE_LEN;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int LOG_MAX     = $clog2(MAX_CODE_LEN + 1) - 1;
  localparam int JW          = LOG_MAX;
  localparam int ACC_W       = 9 + LOG_MAX;
  localparam int EW          = wcdma_pkg::POS_W + 1 + LOG_MAX;
  localparam logic [wcdma_pkg::CLOG_W-1:0] LOG_MAX_C = wcdma_pkg::CLOG_W'(LOG_MAX);
  localparam logic [AW-1:0] CLR_LAST = AW'(STORE_DEPTH - 1);
  localparam logic signed [ACC_W-1:0] LVL_HI = ACC_W'(127);
  localparam logic signed [ACC_W-1:0] LVL_LO = -ACC_W'(128);

  // Configuration registers
  logic [wcdma_pkg::CLOG_W-1:0]  code_log2_r;
  logic [wcdma_pkg::USERS_W-1:0] active_users_r;
  logic                          cfg_wr;

  // Sequencer state
  wcdma_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]                 clr_addr_r;
  logic                          spread_r;
  logic [wcdma_pkg::USER_W-1:0]  user_r;
  logic                          bit_r;
  logic [AW-1:0]                 base_r;
  logic [wcdma_pkg::CLOG_W-1:0]  lg_r;
  logic [JW-1:0]                 jlast_r;
  logic [JW-1:0]                 j_r;
  logic                          iss_r;
  logic                          pend_r;
  logic [JW-1:0]                 pend_j_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic                          out_valid_r;
  logic signed [wcdma_pkg::LEVEL_W-1:0] out_level_r;

  // Item decode
  logic [wcdma_pkg::CLOG_W-1:0]  lg_in;
  logic [EW-1:0]                 base_w;
  logic [EW-1:0]                 end_w;
  logic                          in_live;
  logic                          accept;
  logic                          out_load;

  // RAM and add unit
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [wcdma_pkg::CHIP_W-1:0]  ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [wcdma_pkg::CHIP_W-1:0]  ram_rdata;
  wcdma_pkg::mac_ctrl_t          mac_ctrl;
  logic                          parity;
  logic signed [ACC_W-1:0]       mac_sum;
  logic signed [wcdma_pkg::CHIP_W-1:0] mac_chip;

  // Level division
  logic signed [ACC_W-1:0]       acc_adj;
  logic signed [ACC_W-1:0]       lvl_q;
  logic signed [wcdma_pkg::LEVEL_W-1:0] level_sat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    case (cfg_paddr[2])
      wcdma_pkg::REG_CODE_LOG2: cfg_prdata =
          wcdma_pkg::CFG_DW'(code_log2_r);
      wcdma_pkg::REG_ACTIVE_USERS: cfg_prdata =
          wcdma_pkg::CFG_DW'(active_users_r);
      default: cfg_prdata = '0;
    endcase
  end

  always_comb begin
    lg_in = (code_log2_r == '0) ? wcdma_pkg::CLOG_W'(1) : code_log2_r;
    if (lg_in > LOG_MAX_C) begin
      lg_in = LOG_MAX_C;
    end
    base_w  = EW'(in_bit_position) << lg_in;
    end_w   = (EW'(in_bit_position) + EW'(1)) << lg_in;
    in_live = (in_user < active_users_r) && (32'(end_w) <= 32'(STORE_DEPTH));
    accept  = in_valid & in_ready;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wcdma_pkg::ST_CLEAR: begin
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = wcdma_pkg::ST_IDLE;
        end
      end
      wcdma_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            wcdma_pkg::KIND_CLEAR: state_nxt = wcdma_pkg::ST_CLEAR;
            wcdma_pkg::KIND_SPREAD,
            wcdma_pkg::KIND_DESPREAD: begin
              if (in_live) begin
                state_nxt = wcdma_pkg::ST_RUN;
              end
            end
            default: state_nxt = wcdma_pkg::ST_IDLE;
          endcase
        end
      end
      wcdma_pkg::ST_RUN: begin
        if (pend_r && !iss_r) begin
          state_nxt = spread_r ? wcdma_pkg::ST_IDLE : wcdma_pkg::ST_DONE;
        end
      end
      wcdma_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = wcdma_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wcdma_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    in_ready  = (state_r == wcdma_pkg::ST_IDLE);
    out_load  = (state_r == wcdma_pkg::ST_DONE) && (!out_valid_r || out_ready);
    ram_raddr = base_r | AW'(j_r);
    parity    = ^(user_r[JW-1:0] & pend_j_r);
    mac_ctrl.spread = spread_r;
    // A spread chip goes up when the data sign and the code chip agree.
    mac_ctrl.negate = spread_r ? ~(bit_r ^ parity) : parity;
    ram_we    = 1'b0;
    ram_waddr = base_r | AW'(pend_j_r);
    ram_wdata = mac_chip;
    case (state_r)
      wcdma_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      wcdma_pkg::ST_RUN: begin
        ram_we = pend_r & spread_r;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Truncating division by the code length: bias negative sums first.
  always_comb begin
    acc_adj = acc_r[ACC_W-1] ? (acc_r + $signed(ACC_W'(jlast_r))) : acc_r;
    lvl_q   = acc_adj >>> lg_r;
    if (lvl_q > LVL_HI) begin
      level_sat = 8'sd127;
    end else if (lvl_q < LVL_LO) begin
      level_sat = -8'sd128;
    end else begin
      level_sat = lvl_q[wcdma_pkg::LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= wcdma_pkg::ST_CLEAR;
      clr_addr_r     <= '0;
      iss_r          <= 1'b0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      code_log2_r    <= wcdma_pkg::CODE_LOG2_RST;
      active_users_r <= wcdma_pkg::ACTIVE_USERS_RST;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        case (cfg_paddr[2])
          wcdma_pkg::REG_CODE_LOG2:
            code_log2_r <= cfg_pwdata[wcdma_pkg::CLOG_W-1:0];
          wcdma_pkg::REG_ACTIVE_USERS:
            active_users_r <= cfg_pwdata[wcdma_pkg::USERS_W-1:0];
          default: code_log2_r <= code_log2_r;
        endcase
      end

      case (state_r)
        wcdma_pkg::ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
        end
        wcdma_pkg::ST_IDLE: begin
          if (accept) begin
            clr_addr_r <= '0;
            spread_r   <= (in_kind == wcdma_pkg::KIND_SPREAD);
            user_r     <= in_user;
            bit_r      <= in_data_bit;
            base_r     <= AW'(base_w);
            lg_r       <= lg_in;
            jlast_r    <= JW'((32'd1 << lg_in) - 32'd1);
            j_r        <= '0;
            acc_r      <= '0;
            iss_r      <= in_live && ((in_kind == wcdma_pkg::KIND_SPREAD) ||
                                      (in_kind == wcdma_pkg::KIND_DESPREAD));
          end
        end
        wcdma_pkg::ST_RUN: begin
          // Read of chip j overlaps the update of chip j-1.
          pend_r   <= iss_r;
          pend_j_r <= j_r;
          if (iss_r) begin
            if (j_r == jlast_r) begin
              iss_r <= 1'b0;
            end else begin
              j_r <= j_r + JW'(1);
            end
          end
          if (pend_r && !spread_r) begin
            acc_r <= mac_sum;
          end
        end
        default: iss_r <= 1'b0;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_level_r <= level_sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;

  wcdma_ram #(
    .WIDTH (wcdma_pkg::CHIP_W),
    .DEPTH (STORE_DEPTH)
  ) u_chip_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wcdma_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .ctrl     (mac_ctrl),
    .acc      (acc_r),
    .chip     ($signed(ram_rdata)),
    .sum      (mac_sum),
    .chip_sat (mac_chip)
  );

endmodule : walsh_cdma_spread_despread_top
`default_nettype wire
